### rtl/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

	// Request kind codes
	localparam logic [2:0] KIND_UDEC32 = 3'd0;
	localparam logic [2:0] KIND_SDEC32 = 3'd1;
	localparam logic [2:0] KIND_OCT32  = 3'd2;
	localparam logic [2:0] KIND_HEX32  = 3'd3;
	localparam logic [2:0] KIND_HEX64  = 3'd4;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Digit counts per format
	localparam int DEC32_DIGITS = 10;
	localparam int OCT32_DIGITS = 11;
	localparam int HEX64_DIGITS = 16;

	// Bit-serial decimal conversion
	localparam int CONV_STEPS = 32;
	localparam int CONV_CNT_W = $clog2(CONV_STEPS);
	localparam int BCD_W      = 4 * DEC32_DIGITS;

	typedef enum logic [1:0] {
		FMT_DEC = 2'd0,
		FMT_OCT = 2'd1,
		FMT_HEX = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		PFX_NONE  = 2'd0,
		PFX_MINUS = 2'd1,
		PFX_OCT   = 2'd2,
		PFX_HEX   = 2'd3
	} prefix_t;

	typedef struct packed {
		logic [63:0] mag;
		fmt_t        fmt;
		prefix_t     prefix;
	} item_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] code;
		if (d <= 4'd9) begin
			code = CH_ZERO + {4'h0, d};
		end else begin
			code = CH_A + {4'h0, d} - 8'd10;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

### rtl/integer_to_ascii_formatter.sv
// Order of work: a hex or octal request goes from the queue through the COUNT state to its characters;
// a decimal one first runs the 32-step bit-serial double dabble loop in the CONV state.
// Throughput: one character per cycle while chr_stall is low; the back end holds one request
// at a time and takes the next only once back in idle; a 2-entry queue buffers requests.
// Reset: arst_n clears the sequencer, queue pointers and output valid at once;
// the digit store is not cleared and is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter import itaf_pkg::*; #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [63:0] value,
	input  wire logic [2:0]  kind,
	// Character channel
	output logic             chr_valid,
	input  wire logic        chr_stall,
	output logic [7:0]       char_code,
	output logic             last
);

	item_t front_item;
	item_t q_item;
	logic  push;
	logic  pop;
	logic  q_valid;
	logic  q_full;

	// Front end: classify each request into magnitude, radix and prefix;
	// drop unused kinds without queueing them.
	itaf_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.kind      (kind),
		.q_full    (q_full),
		.push      (push),
		.item      (front_item)
	);

	// Hold classified requests so the front keeps accepting while the
	// back end is busy with a long decimal conversion.
	itaf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (front_item),
		.pop      (pop),
		.rd_item  (q_item),
		.rd_valid (q_valid),
		.full     (q_full)
	);

	// Back end: convert to digits, find the leading digit, then advance
	// through prefix and digits one character per cycle while not stalled, into the output register.
	itaf_back #(
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.pop       (pop),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.char_code (char_code),
		.last      (last)
	);

endmodule

`default_nettype wire

### rtl/itaf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_front import itaf_pkg::*; (
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [63:0] value,
	input  wire logic [2:0]  kind,
	input  wire logic        q_full,
	output logic             push,
	output item_t            item
);

	logic [31:0] low;
	logic        kind_ok;

	assign low       = value[31:0];
	assign req_stall = q_full;

	// Classify the request: magnitude, radix and prefix
	always_comb begin
		kind_ok     = 1'b1;
		item.mag    = {32'h0, low};
		item.fmt    = FMT_DEC;
		item.prefix = PFX_NONE;
		unique case (kind)
			KIND_UDEC32: begin
			end
			KIND_SDEC32: begin
				if (low[31]) begin
					item.prefix = PFX_MINUS;
					item.mag    = {32'h0, 32'h0 - low};
				end
			end
			KIND_OCT32: begin
				item.fmt    = FMT_OCT;
				item.prefix = PFX_OCT;
			end
			KIND_HEX32: begin
				item.fmt    = FMT_HEX;
				item.prefix = PFX_HEX;
			end
			KIND_HEX64: begin
				item.fmt    = FMT_HEX;
				item.prefix = PFX_HEX;
				item.mag    = value;
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	// Drop unused kinds: accepted, never queued
	assign push = req_valid && !q_full && kind_ok;

endmodule

`default_nettype wire

### rtl/itaf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_queue import itaf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wr_item,
	input  wire logic  pop,
	output item_t      rd_item,
	output logic       rd_valid,
	output logic       full
);

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	item_t              entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign rd_item  = entries_q[rd_ptr_q];
	assign rd_valid = (count_q != '0);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### rtl/itaf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_back import itaf_pkg::*; #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_t      q_item,
	input  wire logic       q_valid,
	output logic            pop,
	output logic            chr_valid,
	input  wire logic       chr_stall,
	output logic [7:0]      char_code,
	output logic            last
);

	localparam int IDX_W = $clog2(DIGIT_SLOTS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CONV   = 5'b00010,
		ST_COUNT  = 5'b00100,
		ST_PREFIX = 5'b01000,
		ST_DIGITS = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [CONV_CNT_W-1:0] conv_cnt_q;
	logic                  pre_pos_q;
	logic                  chr_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	fmt_t                  fmt_q;
	prefix_t               prefix_q;
	logic [31:0]           bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BCD_W-1:0]      bcd_next;
	logic [3:0]            digits_q [DIGIT_SLOTS];
	logic [3:0]            load_dig [DIGIT_SLOTS];
	logic [3:0]            dec_dig  [DIGIT_SLOTS];
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      top_idx;
	logic                  out_free;
	logic                  emit;
	logic [7:0]            emit_char;
	logic                  emit_last;
	logic                  conv_done;

	assign out_free  = !chr_valid_q || !chr_stall;
	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign conv_done = (state_q == ST_CONV) && (conv_cnt_q == CONV_CNT_W'(CONV_STEPS - 1));

	// Double dabble step: add three to every BCD digit above four, then shift
	always_comb begin
		for (int i = 0; i < DEC32_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                               : bcd_q[4*i +: 4];
		end
		bcd_next = {bcd_adj[BCD_W-2:0], bin_q[31]};
	end

	// Digit loads: slices for octal and hex, converted digits for decimal
	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			load_dig[i] = 4'h0;
			dec_dig[i]  = 4'h0;
		end
		if (q_item.fmt == FMT_HEX) begin
			for (int i = 0; i < HEX64_DIGITS; i++) begin
				load_dig[i] = q_item.mag[4*i +: 4];
			end
		end else if (q_item.fmt == FMT_OCT) begin
			for (int i = 0; i < OCT32_DIGITS; i++) begin
				load_dig[i] = {1'b0, q_item.mag[3*i +: 3]};
			end
		end
		for (int i = 0; i < DEC32_DIGITS; i++) begin
			dec_dig[i] = bcd_next[4*i +: 4];
		end
	end

	// Most significant nonzero digit; zero keeps a single digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (digits_q[i] != 4'h0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.fmt == FMT_DEC) ? ST_CONV : ST_COUNT;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				state_d = (prefix_q == PFX_NONE) ? ST_DIGITS : ST_PREFIX;
			end
			ST_PREFIX: begin
				if (out_free) begin
					emit = 1'b1;
					unique case (prefix_q)
						PFX_MINUS: emit_char = CH_MINUS;
						PFX_OCT:   emit_char = pre_pos_q ? CH_O : CH_ZERO;
						PFX_HEX:   emit_char = pre_pos_q ? CH_X : CH_ZERO;
						default:   emit_char = CH_ZERO;
					endcase
					if (prefix_q == PFX_MINUS || pre_pos_q) begin
						state_d = ST_DIGITS;
					end
				end
			end
			ST_DIGITS: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = digit_char(digits_q[idx_q]);
					emit_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			conv_cnt_q  <= '0;
			pre_pos_q   <= 1'b0;
			chr_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV) begin
				conv_cnt_q <= conv_cnt_q + 1'b1;
			end else begin
				conv_cnt_q <= '0;
			end
			if (state_q == ST_PREFIX && emit) begin
				pre_pos_q <= 1'b1;
			end else if (state_q != ST_PREFIX) begin
				pre_pos_q <= 1'b0;
			end
			if (emit) begin
				chr_valid_q <= 1'b1;
			end else if (out_free) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		if (pop) begin
			fmt_q    <= q_item.fmt;
			prefix_q <= q_item.prefix;
			bin_q    <= q_item.mag[31:0];
			bcd_q    <= '0;
			digits_q <= load_dig;
		end
		if (state_q == ST_CONV) begin
			bcd_q <= bcd_next;
			bin_q <= {bin_q[30:0], 1'b0};
		end
		if (conv_done) begin
			digits_q <= dec_dig;
		end
		if (state_q == ST_COUNT) begin
			idx_q <= top_idx;
		end
		if (state_q == ST_DIGITS && emit && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	assign chr_valid = chr_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_conv_dec_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (fmt_q == FMT_DEC))
		else $error("conversion running on a non-decimal request");
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE && chr_valid_q && last_q))
		else $error("final character did not close the request");
`endif

endmodule

`default_nettype wire
